FILE: design/pap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pap_pkg - shared types and constants for the priority array placement block
// Field widths, codes, register indexes, state encoding and the structs that
// travel between the controller and the top level.
// ----------------------------------------------------------------------------
package pap_pkg;

    localparam int NUM_CLASSES_DEF = 16;
    localparam int CAPACITY_DEF    = 1024;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CLS_W     = 4;
    localparam int IDX_W     = 10;
    localparam int LIM_W     = 11;

    localparam logic [CFG_W-1:0] BASE_RESET = CFG_W'(16);
    localparam logic [CFG_W-1:0] GROW_RESET = CFG_W'(16);

    typedef enum logic [1:0] {
        K_MOVE = 2'd0,
        K_ADD  = 2'd1,
        K_REM  = 2'd2,
        K_ERR  = 2'd3
    } t_kind;

    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_SIZE = 1'b0,
        REG_GROW_STEP = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_WALK,
        S_DONE,
        S_ERR
    } t_state;

    typedef struct packed {
        logic [CFG_W-1:0] base_size;
        logic [CFG_W-1:0] grow_step;
    } t_cfg;

    typedef struct packed {
        logic             valid;
        t_kind            kind;
        logic [IDX_W-1:0] from_index;
        logic [IDX_W-1:0] dest_index;
        logic [LIM_W-1:0] limit_now;
        logic             last;
    } t_result;

endpackage

FILE: design/pap_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pap_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/pap_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pap_ctrl - region walk sequencer
// Scans class counts up to the target class, decides growth, shrink or error,
// walks the later classes to issue moves, then writes the count back.
// ----------------------------------------------------------------------------
module pap_ctrl
    import pap_pkg::*;
#(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    parameter int CAPACITY    = CAPACITY_DEF,
    localparam int KW = $clog2(NUM_CLASSES),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_opcode,
    input  logic [CLS_W-1:0] i_class_id,
    input  logic [IDX_W-1:0] i_entry_index,
    input  t_cfg             i_cfg,
    output logic             o_busy,
    output logic             o_ram_we,
    output logic [KW-1:0]    o_ram_waddr,
    output logic [CW-1:0]    o_ram_wdata,
    output logic [KW-1:0]    o_ram_raddr,
    input  logic [CW-1:0]    i_ram_rdata,
    output t_result          o_res
);

    localparam int AW = ((CW > CFG_W) ? CW : CFG_W) + 1;
    localparam logic [KW-1:0] K_TOP = KW'(NUM_CLASSES - 1);

    t_state              r_state, n_state;
    t_op                 r_op;
    logic [KW-1:0]       r_cls;
    logic [IDX_W-1:0]    r_idx;
    logic [KW-1:0]       r_k;
    logic [CW-1:0]       r_start, r_c, r_s, r_total, r_limit;
    logic [NUM_CLASSES-1:0] r_vld;

    logic          accept, cls_bad;
    logic [KW-1:0] cls_nx, ram_addr;
    logic [CW-1:0] rd_cnt, w_s_dn, w_s_up;
    logic          walk_end;

    logic [AW-1:0] a_total, a_limit, a_grow, a_base, a_start, a_c, a_idx;
    logic [AW-1:0] a_nl, a_t, rem_end, lastpos, add_limit, rem_limit, chk_limit;
    logic          need_grow, add_err, rem_err, shrink, chk_err, fill_move;

    assign accept  = i_start && (r_state == S_IDLE);
    assign o_busy  = (r_state != S_IDLE);
    assign cls_bad = (int'(i_class_id) >= NUM_CLASSES);
    assign cls_nx  = r_cls + KW'(1);

    // Entries never written read as an empty class
    assign rd_cnt = r_vld[r_k] ? i_ram_rdata : '0;
    assign w_s_dn = r_s - rd_cnt;
    assign w_s_up = r_s + rd_cnt;
    assign walk_end = (r_op == OP_ADD) ? (r_k == cls_nx) : (r_k == K_TOP);

    // Decision datapath, used in the check cycle
    always_comb begin
        a_total   = AW'(r_total);
        a_limit   = AW'(r_limit);
        a_grow    = AW'(i_cfg.grow_step);
        a_base    = AW'(i_cfg.base_size);
        a_start   = AW'(r_start);
        a_c       = AW'(r_c);
        a_idx     = AW'(r_idx);
        need_grow = (a_total + AW'(1)) > a_limit;
        a_nl      = a_limit + a_grow;
        add_err   = need_grow && ((a_nl > AW'(CAPACITY)) || ((a_total + AW'(1)) > a_nl));
        add_limit = need_grow ? a_nl : a_limit;
        rem_end   = a_start + a_c;
        lastpos   = rem_end - AW'(1);
        rem_err   = (r_c == '0) || (a_idx < a_start) || (a_idx >= rem_end);
        a_t       = a_total - AW'(1);
        shrink    = (a_limit >= a_t) && ((a_limit - a_t) >= a_grow) &&
                    (a_grow <= a_limit) && ((a_limit - a_grow) >= a_base);
        rem_limit = shrink ? (a_limit - a_grow) : a_limit;
        chk_err   = (r_op == OP_ADD) ? add_err : rem_err;
        chk_limit = (r_op == OP_ADD) ? add_limit : rem_limit;
        fill_move = (a_idx != lastpos);
    end

    // Read address: the walk issues one class a cycle
    always_comb begin
        unique case (r_state)
            S_IDLE:  ram_addr = '0;
            S_SCAN:  ram_addr = r_k + KW'(1);
            S_CHECK: ram_addr = (r_op == OP_ADD) ? K_TOP : cls_nx;
            S_WALK:  ram_addr = (r_op == OP_ADD) ? (r_k - KW'(1)) : (r_k + KW'(1));
            S_DONE:  ram_addr = r_cls;
            S_ERR:   ram_addr = r_cls;
            default: ram_addr = '0;
        endcase
    end

    assign o_ram_raddr = ram_addr;
    assign o_ram_waddr = r_cls;
    assign o_ram_we    = (r_state == S_DONE);
    assign o_ram_wdata = (r_op == OP_ADD) ? (r_c + CW'(1)) : (r_c - CW'(1));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = cls_bad ? S_ERR : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_k == r_cls) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (chk_err) begin
                    n_state = S_ERR;
                end else if (r_cls == K_TOP) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (walk_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE:  n_state = S_IDLE;
            S_ERR:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Result beats
    always_comb begin
        o_res            = '0;
        o_res.kind       = K_MOVE;
        o_res.limit_now  = LIM_W'(r_limit);
        unique case (r_state)
            S_CHECK: begin
                if (!chk_err && (r_op == OP_REMOVE) && fill_move) begin
                    o_res.valid      = 1'b1;
                    o_res.from_index = IDX_W'(lastpos);
                    o_res.dest_index = r_idx;
                    o_res.limit_now  = LIM_W'(chk_limit);
                end
            end
            S_WALK: begin
                if (rd_cnt != '0) begin
                    o_res.valid = 1'b1;
                    if (r_op == OP_ADD) begin
                        o_res.from_index = IDX_W'(w_s_dn);
                        o_res.dest_index = IDX_W'(r_s);
                    end else begin
                        o_res.from_index = IDX_W'(w_s_up - CW'(1));
                        o_res.dest_index = IDX_W'(r_s - CW'(1));
                    end
                end
            end
            S_DONE: begin
                o_res.valid = 1'b1;
                o_res.last  = 1'b1;
                if (r_op == OP_ADD) begin
                    o_res.kind       = K_ADD;
                    o_res.dest_index = IDX_W'(r_start + r_c);
                end else begin
                    o_res.kind = K_REM;
                end
            end
            S_ERR: begin
                o_res.valid = 1'b1;
                o_res.last  = 1'b1;
                o_res.kind  = K_ERR;
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_total <= '0;
            r_limit <= CW'(BASE_RESET);
            r_vld   <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= ram_addr;
            if (r_state == S_CHECK && !chk_err) begin
                r_limit <= CW'(chk_limit);
            end
            if (r_state == S_DONE) begin
                r_vld[r_cls] <= 1'b1;
                r_total <= (r_op == OP_ADD) ? (r_total + CW'(1)) : (r_total - CW'(1));
            end
        end
    end

    // Per-item working values
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= t_op'(i_opcode);
            r_cls   <= KW'(i_class_id);
            r_idx   <= i_entry_index;
            r_start <= '0;
        end
        if (r_state == S_SCAN) begin
            if (r_k == r_cls) begin
                r_c <= rd_cnt;
            end else begin
                r_start <= r_start + rd_cnt;
            end
        end
        if (r_state == S_CHECK) begin
            r_s <= (r_op == OP_ADD) ? r_total : CW'(rem_end);
        end
        if (r_state == S_WALK) begin
            r_s <= (r_op == OP_ADD) ? w_s_dn : w_s_up;
        end
    end

endmodule

FILE: design/priority_array_placement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_array_placement - region manager for a priority-sorted rule array
// Tracks per-class entry counts and emits the move commands that keep class
// regions packed and ordered on every add and remove.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive start with opcode, class_id and entry_index; the
//   command is taken at an edge where start is high and busy is low.
//   Result channel: each beat sits on the o_ ports for one cycle with o_valid
//   high; moves come first, then one add-done or remove-done beat, or a
//   single error beat. o_last marks the final beat of a command.
//   Configuration: write base_size (index 0) or grow_step (index 1) through
//   i_cfg_we / i_cfg_idx / i_cfg_wdata while the block is idle.
// Timing:
//   Class counts live in a one-port-read RAM; one class is read per cycle.
//   A command holds busy through the scan up to the class, the decision
//   state, the walk of the later classes and the count write-back; a
//   command refused in the decision state holds it through the scan, the
//   decision and the error beat, an unknown class only for the error beat.
//   Beats are registered and appear in the cycle after the controller makes
//   them. A new command is taken at the first edge with busy low.
//   The receiver cannot stall the result channel.
// Reset: synchronous, active low; all counts read as zero and the size
//   limit returns to 16 at once, no clearing pass is needed.
// ----------------------------------------------------------------------------
module priority_array_placement
    import pap_pkg::*;
#(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    parameter int CAPACITY    = CAPACITY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_opcode,
    input  logic [CLS_W-1:0]     i_class_id,
    input  logic [IDX_W-1:0]     i_entry_index,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output logic                 o_valid,
    output logic [1:0]           o_kind,
    output logic [IDX_W-1:0]     o_from_index,
    output logic [IDX_W-1:0]     o_to_index,
    output logic [LIM_W-1:0]     o_limit_now,
    output logic                 o_last
);

    localparam int KW = $clog2(NUM_CLASSES);
    localparam int CW = $clog2(CAPACITY + 1);

    t_cfg             r_cfg;
    t_result          res;
    logic             ram_we;
    logic [KW-1:0]    ram_waddr, ram_raddr;
    logic [CW-1:0]    ram_wdata, ram_rdata;

    logic             r_valid;
    t_kind            r_kind;
    logic [IDX_W-1:0] r_from, r_to;
    logic [LIM_W-1:0] r_limit_now;
    logic             r_last;

    // Configuration registers: plain write, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_size <= BASE_RESET;
            r_cfg.grow_step <= GROW_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_BASE_SIZE: r_cfg.base_size <= i_cfg_wdata;
                REG_GROW_STEP: r_cfg.grow_step <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Class count store
    pap_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_CLASSES)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Scan, decide and walk
    pap_ctrl #(
        .NUM_CLASSES (NUM_CLASSES),
        .CAPACITY    (CAPACITY)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_opcode      (i_opcode),
        .i_class_id    (i_class_id),
        .i_entry_index (i_entry_index),
        .i_cfg         (r_cfg),
        .o_busy        (busy),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata),
        .o_res         (res)
    );

    // Output register: hold each beat for exactly one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_kind      <= res.kind;
            r_from      <= res.from_index;
            r_to        <= res.dest_index;
            r_limit_now <= res.limit_now;
            r_last      <= res.last;
        end
    end

    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_from_index = r_from;
    assign o_to_index   = r_to;
    assign o_limit_now  = r_limit_now;
    assign o_last       = r_valid && r_last;

    // An error beat always closes its command
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == K_ERR)) |-> o_last)
        else $error("error beat not marked last");

    // A move is never the closing beat
    a_move_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == K_MOVE)) |-> !o_last)
        else $error("move beat marked last");

    // The closing beat is not followed directly by another beat
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("beat right after closing beat");

    // An accepted command keeps the block busy on the next cycle
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but block not busy");

endmodule
